// ----- src/assert_macros.svh -----
// Assertion macros for the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition that must hold in the same cycle as its trigger.
`define CHECK_NOW(label, clock, reset, trig, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
    else $error("check failed");

// Check a condition that must hold in the cycle after its trigger.
`define CHECK_NEXT(label, clock, reset, trig, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
    else $error("check failed");

`endif

// ----- src/p12ac_pkg.sv -----
// Types, constants and per-cell arithmetic for the packed 12-bit unpacker.
package p12ac_pkg;

  localparam int PixelBits = 12;
  localparam int ShadeBits = 8;
  localparam int CellCount = ShadeBits;

  localparam logic [PixelBits-1:0] FullScale = '1;
  localparam logic [ShadeBits-1:0] ShadeMax  = '1;
  localparam logic [ShadeBits-1:0] ShadeMin  = '0;

  typedef struct packed {
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [PixelBits-1:0] raw_first;
    logic [PixelBits-1:0] raw_second;
    logic [ShadeBits-1:0] shade_first;
    logic [ShadeBits-1:0] shade_second;
    logic [PixelBits-1:0] frame_low;
    logic [PixelBits-1:0] frame_high;
    logic                 frame_done;
  } out_t;

  // One pixel's division: a settled shade, or a partial remainder plus
  // dividend bits shifting out while quotient bits shift in.
  typedef struct packed {
    logic                 fixed;
    logic [ShadeBits-1:0] fixed_val;
    logic [PixelBits-1:0] rem;
    logic [ShadeBits-1:0] qs;
  } lane_t;

  typedef struct packed {
    lane_t                first;
    lane_t                second;
    logic [PixelBits-1:0] divisor;
    logic [PixelBits-1:0] raw_first;
    logic [PixelBits-1:0] raw_second;
    logic [PixelBits-1:0] frame_low;
    logic [PixelBits-1:0] frame_high;
    logic                 frame_done;
  } item_t;

  // Set up the division of 255*(v-low) by (high-low), or settle the shade
  // outright when the range is empty or the pixel lies outside it.
  function automatic lane_t lane_init(logic [PixelBits-1:0] v,
                                      logic [PixelBits-1:0] plo,
                                      logic [PixelBits-1:0] phi);
    lane_t                          l;
    logic [PixelBits-1:0]           diff;
    logic [PixelBits+ShadeBits-1:0] num;
    diff = v - plo;
    num  = {diff, {ShadeBits{1'b0}}} - {{ShadeBits{1'b0}}, diff};
    l.rem       = num[PixelBits+ShadeBits-1:ShadeBits];
    l.qs        = num[ShadeBits-1:0];
    l.fixed     = 1'b0;
    l.fixed_val = ShadeMin;
    if (phi <= plo) begin
      l.fixed     = 1'b1;
      l.fixed_val = (v > plo) ? ShadeMax : ShadeMin;
    end else if (v <= plo) begin
      l.fixed     = 1'b1;
      l.fixed_val = ShadeMin;
    end else if (v >= phi) begin
      l.fixed     = 1'b1;
      l.fixed_val = ShadeMax;
    end
    return l;
  endfunction

  // One restoring division step: bring down a dividend bit, try the divisor.
  function automatic lane_t lane_step(lane_t l, logic [PixelBits-1:0] d);
    lane_t            r;
    logic [PixelBits:0] trial;
    logic             qbit;
    r     = l;
    trial = {l.rem, l.qs[ShadeBits-1]};
    qbit  = 1'b0;
    if (trial >= {1'b0, d}) begin
      trial = trial - {1'b0, d};
      qbit  = 1'b1;
    end
    r.rem = trial[PixelBits-1:0];
    r.qs  = {l.qs[ShadeBits-2:0], qbit};
    return r;
  endfunction

  // Pick the settled shade or the quotient.
  function automatic logic [ShadeBits-1:0] lane_shade(lane_t l);
    return l.fixed ? l.fixed_val : l.qs;
  endfunction

endpackage

// ----- src/p12ac_front.sv -----
// Entry stage: unpack pixels, track the frame range, set up the divisions.
module p12ac_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  p12ac_pkg::in_t    data,
  output logic              stall,
  input  logic              down_ready,
  output logic              item_valid,
  output p12ac_pkg::item_t  item
);

  logic [p12ac_pkg::PixelBits-1:0] prior_low;
  logic [p12ac_pkg::PixelBits-1:0] prior_high;
  logic [p12ac_pkg::PixelBits-1:0] running_low;
  logic [p12ac_pkg::PixelBits-1:0] running_high;
  logic [p12ac_pkg::PixelBits-1:0] v1;
  logic [p12ac_pkg::PixelBits-1:0] v2;
  logic [p12ac_pkg::PixelBits-1:0] low_next;
  logic [p12ac_pkg::PixelBits-1:0] high_next;
  logic                            ready;
  logic                            accept;

  assign ready  = !item_valid || down_ready;
  assign stall  = !ready;
  assign accept = valid && ready;

  // Unpack both pixels and fold them into the running range.
  always_comb begin
    v1        = {data.byte_zero, data.byte_one[7:4]};
    v2        = {data.byte_two, data.byte_one[3:0]};
    low_next  = running_low;
    high_next = running_high;
    if (v1 < low_next) low_next = v1;
    if (v2 < low_next) low_next = v2;
    if (v1 > high_next) high_next = v1;
    if (v2 > high_next) high_next = v2;
  end

  // Hold the range state and the request for the first cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      prior_low    <= '0;
      prior_high   <= '0;
      running_low  <= p12ac_pkg::FullScale;
      running_high <= '0;
    end else begin
      if (ready) item_valid <= valid;
      if (accept) begin
        if (data.frame_end) begin
          prior_low    <= low_next;
          prior_high   <= high_next;
          running_low  <= p12ac_pkg::FullScale;
          running_high <= '0;
        end else begin
          running_low  <= low_next;
          running_high <= high_next;
        end
      end
    end
  end

  // Capture the request with the range held before it.
  always_ff @(posedge clk) begin
    if (accept) begin
      item.first      <= p12ac_pkg::lane_init(v1, prior_low, prior_high);
      item.second     <= p12ac_pkg::lane_init(v2, prior_low, prior_high);
      item.divisor    <= prior_high - prior_low;
      item.raw_first  <= v1;
      item.raw_second <= v2;
      item.frame_low  <= low_next;
      item.frame_high <= high_next;
      item.frame_done <= data.frame_end;
    end
  end

endmodule

// ----- src/p12ac_cell.sv -----
// Division cell: one quotient bit for both pixels, then hand on.
module p12ac_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  p12ac_pkg::item_t  item_in,
  output logic              ready_out,
  input  logic              ready_in,
  output logic              valid_out,
  output p12ac_pkg::item_t  item_out
);

  p12ac_pkg::item_t item_next;

  assign ready_out = !valid_out || ready_in;

  // Advance the occupancy bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ready_out) begin
      valid_out <= valid_in;
    end
  end

  // Step both divisions and pass the rest along.
  always_comb begin
    item_next        = item_in;
    item_next.first  = p12ac_pkg::lane_step(item_in.first, item_in.divisor);
    item_next.second = p12ac_pkg::lane_step(item_in.second, item_in.divisor);
  end

  // Capture the stepped request.
  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      item_out <= item_next;
    end
  end

endmodule

// ----- src/packed12_unpack_autocontrast.sv -----
// Top level: packed 12-bit pixel unpacker with frame-based contrast stretch.
//
//   channel   direction  handshake                    payload
//   packed    in         packed_valid / packed_stall  packed_data  (p12ac_pkg::in_t)
//   result    out        result_valid / result_stall  result_data  (p12ac_pkg::out_t)
//
// One request enters per cycle while packed_stall is low; each result passes
// through one entry stage plus one cell per shade bit of the divider chain.
// Reset is synchronous; it empties the chain and restores the range state.
// A stalled result holds the last cell; bubbles ahead of it still close up,
// so packed_stall rises only once every stage is occupied.
`include "assert_macros.svh"

module packed12_unpack_autocontrast (
  input  logic              clk,
  input  logic              rst,
  input  logic              packed_valid,
  output logic              packed_stall,
  input  p12ac_pkg::in_t    packed_data,
  output logic              result_valid,
  input  logic              result_stall,
  output p12ac_pkg::out_t   result_data
);

  logic                   vld  [0:p12ac_pkg::CellCount];
  p12ac_pkg::item_t       itm  [0:p12ac_pkg::CellCount];
  logic                   take [1:p12ac_pkg::CellCount+1];
  p12ac_pkg::item_t       last_item;

  p12ac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .valid      (packed_valid),
    .data       (packed_data),
    .stall      (packed_stall),
    .down_ready (take[1]),
    .item_valid (vld[0]),
    .item       (itm[0])
  );

  // Build the divider chain, one cell per shade bit.
  for (genvar i = 0; i < p12ac_pkg::CellCount; i++) begin : g_cell
    p12ac_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vld[i]),
      .item_in   (itm[i]),
      .ready_out (take[i+1]),
      .ready_in  (take[i+2]),
      .valid_out (vld[i+1]),
      .item_out  (itm[i+1])
    );
  end

  assign take[p12ac_pkg::CellCount+1] = !result_stall;

  // Present the last cell as the result.
  assign last_item    = itm[p12ac_pkg::CellCount];
  assign result_valid = vld[p12ac_pkg::CellCount];

  always_comb begin
    result_data.raw_first    = last_item.raw_first;
    result_data.raw_second   = last_item.raw_second;
    result_data.shade_first  = p12ac_pkg::lane_shade(last_item.first);
    result_data.shade_second = p12ac_pkg::lane_shade(last_item.second);
    result_data.frame_low    = last_item.frame_low;
    result_data.frame_high   = last_item.frame_high;
    result_data.frame_done   = last_item.frame_done;
  end

  `CHECK_NOW(a_range_order, clk, rst, result_valid, result_data.frame_low <= result_data.frame_high)
  `CHECK_NOW(a_first_in_range, clk, rst, result_valid, (result_data.raw_first >= result_data.frame_low) && (result_data.raw_first <= result_data.frame_high))
  `CHECK_NOW(a_second_in_range, clk, rst, result_valid, (result_data.raw_second >= result_data.frame_low) && (result_data.raw_second <= result_data.frame_high))
  `CHECK_NOW(a_stall_when_full, clk, rst, packed_stall, vld[0] && result_valid && result_stall)

endmodule
